// ----- src/cke_pkg.sv -----
// shared types and constants for the calculator keypad entry editor
`default_nettype none

package cke_pkg;

    localparam int STORE_DIGITS   = 10;
    localparam int MANT_W         = 4 * STORE_DIGITS;
    localparam int MAX_DIGITS_DEF = 10;

    localparam logic [3:0] EXP_DIGIT_LIMIT = 4'd8;
    localparam logic [3:0] EE_TRIM_COUNT   = 4'd9;
    localparam logic [3:0] STORE_COUNT     = 4'd10;
    localparam logic [6:0] EXP_MAX         = 7'd99;

    // key opcodes
    localparam logic [3:0] OP_DIGIT    = 4'd0;
    localparam logic [3:0] OP_DOT      = 4'd1;
    localparam logic [3:0] OP_CHS      = 4'd2;
    localparam logic [3:0] OP_EE       = 4'd3;
    localparam logic [3:0] OP_UNDO_EE  = 4'd4;
    localparam logic [3:0] OP_CLEAR    = 4'd5;
    localparam logic [3:0] OP_CLR_ENTRY = 4'd6;
    localparam logic [3:0] OP_BLINK    = 4'd7;
    localparam logic [3:0] OP_LOAD     = 4'd8;

    // entry modes
    localparam logic [1:0] MODE_REG  = 2'd0;
    localparam logic [1:0] MODE_MANT = 2'd1;
    localparam logic [1:0] MODE_EXP  = 2'd2;

    typedef struct packed {
        logic [3:0]        opcode;
        logic [3:0]        key_digit;
        logic              load_negative;
        logic [MANT_W-1:0] load_mantissa;
        logic [3:0]        load_digit_count;
        logic              load_has_dot;
        logic [3:0]        load_dot_after;
        logic              load_has_exp;
        logic              load_exp_negative;
        logic [6:0]        load_exponent;
    } t_key;

    typedef struct packed {
        logic              neg;
        logic [MANT_W-1:0] mant;
        logic [3:0]        count;
        logic              has_dot;
        logic [3:0]        dot_after;
        logic              has_exp;
        logic              exp_neg;
        logic [6:0]        exp_val;
        logic [1:0]        mode;
        logic              sci;
        logic              blink;
    } t_disp;

endpackage

`default_nettype wire

// ----- src/cke_next.sv -----
// next display state for one key
`default_nettype none

module cke_next #(
    parameter int MAX_DIGITS = cke_pkg::MAX_DIGITS_DEF
) (
    input  cke_pkg::t_key  i_key,
    input  cke_pkg::t_disp i_cur,
    output cke_pkg::t_disp o_nxt
);

    localparam int LIMIT_INT = (MAX_DIGITS < cke_pkg::STORE_DIGITS) ?
                               MAX_DIGITS : cke_pkg::STORE_DIGITS;
    localparam logic [3:0] MANT_LIMIT = 4'(LIMIT_INT);

    function automatic logic [cke_pkg::MANT_W-1:0] digit_mask(input logic [3:0] n);
        logic [cke_pkg::MANT_W-1:0] m;
        m = '0;
        for (int i = 0; i < cke_pkg::STORE_DIGITS; i++) begin
            if (4'(i) < n) m[4*i +: 4] = 4'hF;
        end
        return m;
    endfunction

    logic [3:0]                 top_nib;
    logic                       lead_zd;
    logic [3:0]                 cnt_m1;
    logic [3:0]                 limit;
    logic [cke_pkg::MANT_W-1:0] drop_mant;
    logic [cke_pkg::MANT_W-1:0] dig_ext;
    logic [14:0]                exp_prod;
    logic [3:0]                 exp_q;
    logic [6:0]                 exp_rem;
    logic [6:0]                 exp_shift;
    logic [3:0]                 ld_cnt;
    logic [3:0]                 ld_pos;
    logic [6:0]                 ld_exp;

    // leading digit of the mantissa
    always_comb begin
        top_nib = '0;
        for (int i = 0; i < cke_pkg::STORE_DIGITS; i++) begin
            if (i_cur.count == 4'(i + 1)) top_nib = i_cur.mant[4*i +: 4];
        end
    end

    assign lead_zd   = (top_nib == 4'd0) && i_cur.has_dot && (i_cur.dot_after == 4'd1);
    assign cnt_m1    = i_cur.count - 4'd1;
    assign drop_mant = i_cur.mant & digit_mask(cnt_m1);
    assign limit     = i_cur.has_exp ? cke_pkg::EXP_DIGIT_LIMIT : MANT_LIMIT;
    assign dig_ext   = cke_pkg::MANT_W'(i_key.key_digit);

    // exponent mod 10 via reciprocal multiply, exact below 128
    assign exp_prod  = 15'(i_cur.exp_val) * 15'd205;
    assign exp_q     = exp_prod[14:11];
    assign exp_rem   = i_cur.exp_val - ({3'b0, exp_q} * 7'd10);
    assign exp_shift = 7'({3'b0, exp_rem[3:0]} * 7'd10) + {3'b0, i_key.key_digit};

    // load saturation
    always_comb begin
        if (i_key.load_digit_count == 4'd0) begin
            ld_cnt = 4'd1;
        end else if (i_key.load_digit_count > cke_pkg::STORE_COUNT) begin
            ld_cnt = cke_pkg::STORE_COUNT;
        end else begin
            ld_cnt = i_key.load_digit_count;
        end
        ld_pos = (i_key.load_dot_after > ld_cnt) ? ld_cnt : i_key.load_dot_after;
        ld_exp = (i_key.load_exponent > cke_pkg::EXP_MAX) ? cke_pkg::EXP_MAX :
                 i_key.load_exponent;
    end

    always_comb begin
        o_nxt = i_cur;
        case (i_key.opcode)
            cke_pkg::OP_DIGIT: begin
                if (i_key.key_digit <= 4'd9) begin
                    if (i_cur.mode == cke_pkg::MODE_REG) begin
                        o_nxt.neg       = 1'b0;
                        o_nxt.mant      = dig_ext;
                        o_nxt.count     = 4'd1;
                        o_nxt.has_dot   = 1'b0;
                        o_nxt.dot_after = 4'd0;
                        o_nxt.has_exp   = 1'b0;
                        o_nxt.exp_neg   = 1'b0;
                        o_nxt.exp_val   = 7'd0;
                        o_nxt.mode      = cke_pkg::MODE_MANT;
                    end else if (i_cur.mode == cke_pkg::MODE_EXP) begin
                        o_nxt.exp_val = exp_shift;
                    end else if (i_cur.count == 4'd1 && !i_cur.has_dot &&
                                 i_cur.mant[3:0] == 4'd0) begin
                        // lone zero is replaced
                        o_nxt.mant = dig_ext;
                    end else if (i_cur.count >= limit) begin
                        // full: only "0." can make room
                        if (lead_zd) begin
                            o_nxt.dot_after = 4'd0;
                            o_nxt.mant      = (drop_mant << 4) | dig_ext;
                        end
                    end else begin
                        o_nxt.mant  = (i_cur.mant << 4) | dig_ext;
                        o_nxt.count = i_cur.count + 4'd1;
                    end
                end
            end
            cke_pkg::OP_DOT: begin
                if (i_cur.mode == cke_pkg::MODE_REG) begin
                    o_nxt.neg       = 1'b0;
                    o_nxt.mant      = '0;
                    o_nxt.count     = 4'd1;
                    o_nxt.has_dot   = 1'b1;
                    o_nxt.dot_after = 4'd1;
                    o_nxt.has_exp   = 1'b0;
                    o_nxt.exp_neg   = 1'b0;
                    o_nxt.exp_val   = 7'd0;
                    o_nxt.mode      = cke_pkg::MODE_MANT;
                end else begin
                    o_nxt.mode = cke_pkg::MODE_MANT;
                    if (!i_cur.has_dot) begin
                        o_nxt.has_dot   = 1'b1;
                        o_nxt.dot_after = i_cur.count;
                    end
                end
            end
            cke_pkg::OP_CHS: begin
                if (i_cur.mode == cke_pkg::MODE_EXP) begin
                    o_nxt.exp_neg = ~i_cur.exp_neg;
                end else begin
                    o_nxt.neg = ~i_cur.neg;
                end
            end
            cke_pkg::OP_EE: begin
                o_nxt.sci = 1'b1;
                if (i_cur.mode != cke_pkg::MODE_EXP) begin
                    if (i_cur.has_exp) begin
                        o_nxt.mode = cke_pkg::MODE_EXP;
                    end else if (i_cur.count == cke_pkg::EE_TRIM_COUNT && lead_zd) begin
                        // "0." with nine digits gives up its zero for the exponent
                        o_nxt.count     = cnt_m1;
                        o_nxt.dot_after = 4'd0;
                        o_nxt.mant      = drop_mant;
                        o_nxt.has_exp   = 1'b1;
                        o_nxt.exp_neg   = 1'b0;
                        o_nxt.exp_val   = 7'd0;
                        o_nxt.mode      = cke_pkg::MODE_EXP;
                    end else if (i_cur.count <= cke_pkg::EXP_DIGIT_LIMIT) begin
                        o_nxt.has_exp = 1'b1;
                        o_nxt.exp_neg = 1'b0;
                        o_nxt.exp_val = 7'd0;
                        o_nxt.mode    = cke_pkg::MODE_EXP;
                    end else begin
                        o_nxt.mode = cke_pkg::MODE_MANT;
                    end
                end
            end
            cke_pkg::OP_UNDO_EE: begin
                o_nxt.sci = 1'b0;
                if (i_cur.mode != cke_pkg::MODE_REG) begin
                    o_nxt.mode = cke_pkg::MODE_MANT;
                    if (i_cur.has_exp && !i_cur.exp_neg && i_cur.exp_val == 7'd0) begin
                        o_nxt.has_exp = 1'b0;
                    end
                end
            end
            cke_pkg::OP_CLEAR, cke_pkg::OP_CLR_ENTRY: begin
                o_nxt.blink = 1'b0;
                if (i_key.opcode == cke_pkg::OP_CLEAR) o_nxt.sci = 1'b0;
                if (i_key.opcode == cke_pkg::OP_CLEAR || i_cur.mode != cke_pkg::MODE_REG) begin
                    o_nxt.neg       = 1'b0;
                    o_nxt.mant      = '0;
                    o_nxt.count     = 4'd1;
                    o_nxt.has_dot   = 1'b0;
                    o_nxt.dot_after = 4'd0;
                    o_nxt.has_exp   = 1'b0;
                    o_nxt.exp_neg   = 1'b0;
                    o_nxt.exp_val   = 7'd0;
                    o_nxt.mode      = cke_pkg::MODE_MANT;
                end
            end
            cke_pkg::OP_BLINK: begin
                o_nxt.blink = 1'b1;
            end
            cke_pkg::OP_LOAD: begin
                o_nxt.neg       = i_key.load_negative;
                o_nxt.count     = ld_cnt;
                o_nxt.mant      = i_key.load_mantissa & digit_mask(ld_cnt);
                o_nxt.has_dot   = i_key.load_has_dot;
                o_nxt.dot_after = i_key.load_has_dot ? ld_pos : 4'd0;
                o_nxt.has_exp   = i_key.load_has_exp;
                o_nxt.exp_neg   = i_key.load_has_exp & i_key.load_exp_negative;
                o_nxt.exp_val   = i_key.load_has_exp ? ld_exp : 7'd0;
                o_nxt.mode      = cke_pkg::MODE_REG;
            end
            default: begin
                o_nxt = i_cur;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- src/calculator_keypad_entry_editor_top.sv -----
// top level of the calculator keypad entry editor: key stream in, display stream out
//
// channel   dir  tdata                                   tuser
// s (key)   in   key fields, 64 bits                     opcode
// m (disp)  out  display fields, 64 bits                 none
//
// one key per cycle while the output is not stalled; a key waits in the input register, and the
// display update lands in the state register, which is also the output register
// reset clears the display to a lone editable zero, with no transfer pending
// a stalled output holds the state, and the input register keeps taking one
// key while the output waits
`default_nettype none

module calculator_keypad_entry_editor_top #(
    parameter int MAX_DIGITS = cke_pkg::MAX_DIGITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    // key_digit[3:0], load_negative[4], load_mantissa[44:5],
    // load_digit_count[48:45], load_has_dot[49], load_dot_after[53:50],
    // load_has_exp[54], load_exp_negative[55], load_exponent[62:56], zero[63]
    input  wire logic [63:0] i_s_tdata,
    // opcode[3:0]
    input  wire logic [3:0]  i_s_tuser,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // shown_negative[0], shown_mantissa[40:1], shown_digit_count[44:41],
    // shown_has_dot[45], shown_dot_after[49:46], shown_has_exp[50],
    // shown_exp_negative[51], shown_exponent[58:52], shown_mode[60:59],
    // shown_sci[61], shown_blinking[62], zero[63]
    output logic [63:0]      o_m_tdata
);

    logic           r_in_valid;
    cke_pkg::t_key  r_key;
    logic           r_out_valid;
    cke_pkg::t_disp r_state;
    cke_pkg::t_disp n_state;
    logic           out_free;
    logic           proc;
    logic           s_xfer;

    assign out_free   = !r_out_valid || i_m_tready;
    assign proc       = r_in_valid && out_free;
    assign o_s_tready = !r_in_valid || out_free;
    assign s_xfer     = i_s_tvalid && o_s_tready;

    cke_next #(
        .MAX_DIGITS(MAX_DIGITS)
    ) u_next (
        .i_key(r_key),
        .i_cur(r_state),
        .o_nxt(n_state)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_xfer) begin
            r_key.opcode            <= i_s_tuser;
            r_key.key_digit         <= i_s_tdata[3:0];
            r_key.load_negative     <= i_s_tdata[4];
            r_key.load_mantissa     <= i_s_tdata[44:5];
            r_key.load_digit_count  <= i_s_tdata[48:45];
            r_key.load_has_dot      <= i_s_tdata[49];
            r_key.load_dot_after    <= i_s_tdata[53:50];
            r_key.load_has_exp      <= i_s_tdata[54];
            r_key.load_exp_negative <= i_s_tdata[55];
            r_key.load_exponent     <= i_s_tdata[62:56];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid       <= 1'b0;
            r_state.neg       <= 1'b0;
            r_state.mant      <= '0;
            r_state.count     <= 4'd1;
            r_state.has_dot   <= 1'b0;
            r_state.dot_after <= 4'd0;
            r_state.has_exp   <= 1'b0;
            r_state.exp_neg   <= 1'b0;
            r_state.exp_val   <= 7'd0;
            r_state.mode      <= cke_pkg::MODE_MANT;
            r_state.sci       <= 1'b0;
            r_state.blink     <= 1'b0;
        end else begin
            if (out_free) r_out_valid <= r_in_valid;
            if (proc) r_state <= n_state;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_state.blink, r_state.sci, r_state.mode, r_state.exp_val,
                         r_state.exp_neg, r_state.has_exp, r_state.dot_after,
                         r_state.has_dot, r_state.count, r_state.mant, r_state.neg};

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.count != 4'd0 && r_state.count <= cke_pkg::STORE_COUNT)
        else $error("digit count out of range");

    a_dot_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.dot_after <= r_state.count)
        else $error("dot position beyond digit count");

    a_exp_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_state.has_exp |-> (!r_state.exp_neg && r_state.exp_val == 7'd0))
        else $error("exponent fields set without exponent");

    a_exp_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.exp_val <= cke_pkg::EXP_MAX && r_state.mode <= cke_pkg::MODE_EXP)
        else $error("exponent or mode out of range");

    a_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !proc |=> $stable(r_state))
        else $error("display changed without a key");
`endif

endmodule

`default_nettype wire
